// ===== rtl/core/dq_pkg.sv =====
// Shared constants, codes and types for the double-ended queue.
`default_nettype none

package dq_pkg;

  localparam int DQ_DEPTH = 16;
  localparam int DQ_AW    = (DQ_DEPTH > 1) ? $clog2(DQ_DEPTH) : 1;
  localparam int DQ_CW    = $clog2(DQ_DEPTH + 1);
  localparam int DQ_DW    = 32;

  localparam int DQ_IN_BITS  = 3 + DQ_DW;
  localparam int DQ_IN_W     = ((DQ_IN_BITS + 7) / 8) * 8;
  localparam int DQ_OUT_BITS = 2 * DQ_DW + DQ_CW + 4;
  localparam int DQ_OUT_W    = ((DQ_OUT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_CLEAR      = 3'd4
  } dq_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } dq_status_t;

  // Write request from the pointer logic to the ring store.
  typedef struct packed {
    logic             en;
    logic [DQ_AW-1:0] addr;
    logic [DQ_DW-1:0] data;
  } dq_wr_t;

  // Read addresses and bookkeeping after the latest operation.
  typedef struct packed {
    logic [DQ_AW-1:0] front_addr;
    logic [DQ_AW-1:0] back_addr;
    logic [DQ_CW-1:0] count;
    dq_status_t       status;
  } dq_view_t;

endpackage

`default_nettype wire

// ===== rtl/core/dq_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dq_ctrl.sv =====
// Head pointer, element count and status, with the store write for each operation.
`default_nettype none

module dq_ctrl import dq_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [2:0]       operation,
  input  wire logic [DQ_DW-1:0] value,
  output dq_wr_t                wr,
  output dq_view_t              view
);

  logic [DQ_AW-1:0] head, head_next;
  logic [DQ_CW-1:0] count, count_next;
  dq_status_t       status, status_next;
  logic [DQ_CW-1:0] count_m1;
  logic             full, empty;

  // Ring addition of two in-range indices; the sum stays below twice the depth.
  function automatic logic [DQ_AW-1:0] ring_add(input logic [DQ_AW-1:0] a,
                                                input logic [DQ_AW-1:0] b);
    logic [DQ_AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (DQ_AW+1)'(DQ_DEPTH)) begin
      s = s - (DQ_AW+1)'(DQ_DEPTH);
    end
    return s[DQ_AW-1:0];
  endfunction

  assign full     = (count == DQ_CW'(DQ_DEPTH));
  assign empty    = (count == '0);
  assign count_m1 = count - DQ_CW'(1);

  always_comb begin
    head_next   = head;
    count_next  = count;
    status_next = ST_OK;
    wr.en       = 1'b0;
    wr.addr     = head;
    wr.data     = value;
    case (dq_op_t'(operation))
      OP_PUSH_BACK: begin
        if (full) begin
          status_next = ST_PUSH_FULL;
        end else begin
          wr.en      = step;
          wr.addr    = ring_add(head, count[DQ_AW-1:0]);
          count_next = count + DQ_CW'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_PUSH_FULL;
        end else begin
          head_next  = (head == '0) ? DQ_AW'(DQ_DEPTH - 1) : head - DQ_AW'(1);
          wr.en      = step;
          wr.addr    = head_next;
          count_next = count + DQ_CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_next = ST_POP_EMPTY;
        end else begin
          count_next = count_m1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_next = ST_POP_EMPTY;
        end else begin
          head_next  = (head == DQ_AW'(DQ_DEPTH - 1)) ? '0 : head + DQ_AW'(1);
          count_next = count_m1;
        end
      end
      OP_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      status <= ST_OK;
    end else if (step) begin
      head   <= head_next;
      count  <= count_next;
      status <= status_next;
    end
  end

  // An empty queue points the back read at the head; the result is masked anyway.
  assign view.front_addr = head;
  assign view.back_addr  = empty ? head : ring_add(head, count_m1[DQ_AW-1:0]);
  assign view.count      = count;
  assign view.status     = status;

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_queue.sv =====
// Top level of the double-ended queue: handshake sequencing around the ring store.
//
//  Port group  Dir  Contents (lowest bit first)
//  s_*         in   operation[2:0], value[34:3], zero fill to 40 bits
//  m_*         out  front_value, back_value, count, is_empty, is_full, status
//
// The result of a transaction is offered in S_SHOW: acceptance in S_IDLE updates the
// pointers and writes the store, S_READ reads front and back from the store, and S_SHOW
// presents the registered read data.
// One transaction is in flight at a time; s_tready stays low until the result is taken.
// Reset (rst, synchronous) empties the queue; store contents are left as they are.
`default_nettype none

module double_ended_queue import dq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // operation[2:0], value[34:3], zero fill above
  input  wire logic [DQ_IN_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // front_value[31:0], back_value[63:32], count[68:64], is_empty[69],
  // is_full[70], status[72:71], zero fill above
  output logic      [DQ_OUT_W-1:0] m_tdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHOW
  } state_t;

  state_t           state;
  logic             step;
  dq_wr_t           wr;
  dq_view_t         view;
  logic [DQ_DW-1:0] rd_front, rd_back;
  logic             is_empty, is_full;
  logic [DQ_DW-1:0] front_value, back_value;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_SHOW);
  assign step     = s_tvalid & s_tready;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .operation (s_tdata[2:0]),
    .value     (s_tdata[DQ_DW+2:3]),
    .wr        (wr),
    .view      (view)
  );

  dq_ram #(
    .WIDTH (DQ_DW),
    .DEPTH (DQ_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (wr.en),
    .waddr   (wr.addr),
    .wdata   (wr.data),
    .re      (state == S_READ),
    .raddr_a (view.front_addr),
    .raddr_b (view.back_addr),
    .rdata_a (rd_front),
    .rdata_b (rd_back)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (step) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign is_empty    = (view.count == '0);
  assign is_full     = (view.count == DQ_CW'(DQ_DEPTH));
  assign front_value = is_empty ? '0 : rd_front;
  assign back_value  = is_empty ? '0 : rd_back;

  assign m_tdata = {{(DQ_OUT_W - DQ_OUT_BITS){1'b0}}, view.status, is_full, is_empty,
                    view.count, back_value, front_value};

endmodule

`default_nettype wire
